/* src/hcbp_pkg.sv */
// hcbp_pkg: shared types and constants for the Huffman code bit packer.
// No dependencies; compiled first.
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int SYM_W     = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int FILL_W    = 3;
    localparam int MAX_BYTES = 4;
    localparam int CNT_W     = 3;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAD  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // One burst of results handed from the packing stage to the output queue
    typedef struct packed {
        logic [CNT_W-1:0]            cnt;
        logic [MAX_BYTES*BYTE_W-1:0] data;
        logic                        err;
        logic                        flush;
    } t_emit_load;

endpackage

`default_nettype wire

/* src/hcbp_ifs.sv */
// hcbp_ifs: valid/ready channel interfaces for commands and result words.
// Depends on hcbp_pkg.
`default_nettype none

interface hcbp_cmd_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_len;

    modport source (output valid, cmd, symbol, code_value, code_len, input ready);
    modport sink   (input valid, cmd, symbol, code_value, code_len, output ready);
endinterface

interface hcbp_res_if;
    import hcbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    t_kind             out_kind;
    logic              last;

    modport source (output valid, out_byte, out_kind, last, input ready);
    modport sink   (input valid, out_byte, out_kind, last, output ready);
endinterface

`default_nettype wire

/* src/hcbp_emitter.sv */
// hcbp_emitter: output queue that holds up to four result words of one item
// and drives them out one per handshake. Depends on hcbp_pkg and hcbp_ifs.
`default_nettype none

module hcbp_emitter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  hcbp_pkg::t_emit_load   i_load,
    input  logic                   i_load_en,
    output logic                   o_free,
    hcbp_res_if.source             o_res_if
);
    import hcbp_pkg::*;

    logic [CNT_W-1:0]            r_cnt;
    logic [MAX_BYTES*BYTE_W-1:0] r_data;
    logic                        r_err;
    logic                        r_flush;
    logic                        out_acc;

    assign out_acc = o_res_if.valid && o_res_if.ready;

    // Present the head word straight from the registers
    assign o_res_if.valid    = (r_cnt != '0);
    assign o_res_if.out_byte = r_data[MAX_BYTES*BYTE_W-1 -: BYTE_W];
    assign o_res_if.last     = (r_cnt == CNT_W'(1));
    always_comb begin
        if (r_err) begin
            o_res_if.out_kind = KIND_ERR;
        end else if (r_flush && r_cnt == CNT_W'(1)) begin
            o_res_if.out_kind = KIND_PAD;
        end else begin
            o_res_if.out_kind = KIND_DATA;
        end
    end

    // Free when empty, or once the last queued word leaves in this cycle
    assign o_free = (r_cnt == '0) || (r_cnt == CNT_W'(1) && out_acc);

    // Advance the word count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load_en) begin
            r_cnt <= i_load.cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Load a burst, or shift the next word to the head
    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_data  <= i_load.data;
            r_err   <= i_load.err;
            r_flush <= i_load.flush;
        end else if (out_acc) begin
            r_data <= {r_data[(MAX_BYTES-1)*BYTE_W-1:0], BYTE_W'(0)};
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load_en |-> o_free)
        else $error("emitter loaded while words still pending");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_BYTES))
        else $error("emitter count beyond four words");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && r_cnt != '0) |-> (r_cnt == CNT_W'(1)))
        else $error("error result queued with other words");

endmodule

`default_nettype wire

/* src/huffman_code_bit_packer_unit.sv */
// Huffman code bit packer: table-driven encoder packing codes MSB first.
// Depends on hcbp_pkg, hcbp_ifs and hcbp_emitter.
//
// Usage:
//   i_cmd_if carries command words: load a table entry (symbol, code_value,
//   code_len), encode a symbol, or flush the partial byte. o_res_if carries
//   result words: data bytes, the padding count after a flush, or an error
//   word for an unmapped symbol. last marks the final word of one command.
//   A command is taken every cycle while the packing stage is empty or passes
//   its command on. Its table entry is read from the code and length memories
//   at acceptance, and the packing stage merges the code into the partial
//   byte in the next cycle, then loads its burst into the output queue, which
//   shows the head word on o_res_if. Up to four words follow one encode; the
//   queue sends one per cycle while the receiver is ready; a command making
//   words waits in the stage until the queue is free; others keep flowing.
//   Loads write the memories at acceptance, so a following encode of the same
//   symbol sees the new entry. Reset clears the per-symbol valid bits, the
//   partial byte and the queue at once; no clearing pass is needed. When the
//   receiver stalls, the queue holds its words and intake stops once the
//   packing stage holds a command whose burst cannot load.
`default_nettype none

module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbp_cmd_if.sink   i_cmd_if,
    hcbp_res_if.source o_res_if
);
    import hcbp_pkg::*;

    localparam int AddrW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LenCap = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int WinW   = BYTE_W + CODE_W;

    // Table memories and per-symbol valid bits
    logic [CODE_W-1:0]       r_code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        r_len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_valid;

    logic [CODE_W-1:0] r_rd_code;
    logic [LEN_W-1:0]  r_rd_len;

    // Packing stage
    logic              r_s1_valid;
    logic [1:0]        r_s1_cmd;
    logic              r_s1_inrange;
    logic              r_s1_vld;
    logic [BYTE_W-1:0] r_partial;
    logic [FILL_W-1:0] r_bits_filled;

    logic              acc;
    logic [AddrW-1:0]  in_idx;
    logic              in_range;
    logic [LEN_W-1:0]  len_sat;
    logic              is_load;

    logic              mapped;
    logic [CODE_W:0]   mask33;
    logic [CODE_W-1:0] code_m;
    logic [6:0]        total;
    logic [5:0]        shamt;
    logic [WinW-1:0]   win;
    logic [CNT_W-1:0]  n_bytes;
    logic [BYTE_W-1:0] next_byte;
    logic [BYTE_W-1:0] pad;
    logic [BYTE_W-1:0] n_partial;
    logic [FILL_W-1:0] n_bits_filled;
    t_emit_load        ld;
    logic              s1_fire;
    logic              em_free;

    assign acc      = i_cmd_if.valid && i_cmd_if.ready;
    assign in_idx   = i_cmd_if.symbol[AddrW-1:0];
    assign in_range = ({1'b0, i_cmd_if.symbol} < 9'(SYMBOL_COUNT));
    assign is_load  = (i_cmd_if.cmd == CMD_LOAD);
    assign len_sat  = (i_cmd_if.code_len > LEN_W'(LenCap)) ? LEN_W'(LenCap)
                                                           : i_cmd_if.code_len;

    // Write a load, read the entry for every accepted word
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (is_load && in_range) begin
                r_code_mem[in_idx] <= i_cmd_if.code_value;
                r_len_mem[in_idx]  <= len_sat;
            end
            r_rd_code <= r_code_mem[in_idx];
            r_rd_len  <= r_len_mem[in_idx];
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (acc && is_load && in_range) begin
            r_valid[in_idx] <= 1'b1;
        end
    end

    // Advance the command into the packing stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_cmd     <= i_cmd_if.cmd;
            r_s1_inrange <= in_range;
            r_s1_vld     <= r_valid[in_idx];
        end
    end

    // Merge the code into the partial byte
    always_comb begin
        mapped  = r_s1_inrange && r_s1_vld && (r_rd_len != '0);
        mask33  = (33'd1 << r_rd_len) - 33'd1;
        code_m  = r_rd_code & mask33[CODE_W-1:0];
        total   = 7'(r_bits_filled) + 7'(r_rd_len);
        shamt   = 6'(WinW) - total[5:0];
        win     = {r_partial, CODE_W'(0)} | (WinW'(code_m) << shamt);
        n_bytes = total[5:3];
        pad     = BYTE_W'(8) - BYTE_W'(r_bits_filled);
        case (n_bytes)
            3'd0:    next_byte = win[39:32];
            3'd1:    next_byte = win[31:24];
            3'd2:    next_byte = win[23:16];
            3'd3:    next_byte = win[15:8];
            default: next_byte = win[7:0];
        endcase
    end

    // Decode the command into a burst and the next packer state
    always_comb begin
        ld            = '0;
        n_partial     = r_partial;
        n_bits_filled = r_bits_filled;
        unique case (r_s1_cmd)
            CMD_ENCODE: begin
                if (mapped) begin
                    ld.cnt        = n_bytes;
                    ld.data       = win[WinW-1:BYTE_W];
                    n_partial     = next_byte;
                    n_bits_filled = total[FILL_W-1:0];
                end else begin
                    ld.cnt = CNT_W'(1);
                    ld.err = 1'b1;
                end
            end
            CMD_FLUSH: begin
                ld.flush = 1'b1;
                if (r_bits_filled != '0) begin
                    ld.cnt  = CNT_W'(2);
                    ld.data = {r_partial, pad, 16'd0};
                end else begin
                    ld.cnt  = CNT_W'(1);
                    ld.data = '0;
                end
                n_partial     = '0;
                n_bits_filled = '0;
            end
            default: begin
                ld = '0;
            end
        endcase
    end

    assign s1_fire        = r_s1_valid && ((ld.cnt == '0) || em_free);
    assign i_cmd_if.ready = !r_s1_valid || s1_fire;

    // Update the partial byte as each command leaves the stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial     <= '0;
            r_bits_filled <= '0;
        end else if (s1_fire) begin
            r_partial     <= n_partial;
            r_bits_filled <= n_bits_filled;
        end
    end

    hcbp_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (ld),
        .i_load_en (s1_fire && (ld.cnt != '0)),
        .o_free    (em_free),
        .o_res_if  (o_res_if)
    );

    a_empty_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bits_filled == '0) |-> (r_partial == '0))
        else $error("partial byte holds bits with zero fill");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_cmd == CMD_FLUSH) |=> (r_bits_filled == '0))
        else $error("flush left bits pending");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_cmd)))
        else $error("packing stage dropped a stalled command");

endmodule

`default_nettype wire

/* dv/hcbp_packed_word_checker.sv */
`timescale 1ns / 100ps
// hcbp_packed_word_checker: watches the command and result channels of the bit packer,
// predicts the packed words of each accepted command and compares them in order.
// Depends on hcbp_pkg and hcbp_ifs.
`default_nettype none

module hcbp_packed_word_checker #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hcbp_cmd_if  i_cmd_mon,
    hcbp_res_if  i_res_mon,
    output int   o_fail_count,
    output int   o_owed_count
);
    import hcbp_pkg::*;

    localparam int LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    typedef struct {
        logic [BYTE_W-1:0] data;
        t_kind             kind;
        logic              last;
    } t_out_word;

    // Mirror of the code table and the partial byte
    logic [CODE_W-1:0] code_tbl [256];
    logic [LEN_W-1:0]  len_tbl  [256];
    logic [BYTE_W-1:0] acc_byte;
    int                acc_fill;

    t_out_word owed_words [$];
    int        mismatches;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: packed word mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Work out the words that one command produces and queue them
    task automatic pack_command(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                input logic [CODE_W-1:0] value,
                                input logic [LEN_W-1:0] len);
        int                clen;
        int                n;
        logic [CODE_W-1:0] code;
        clen = 0;
        n    = 0;
        case (op)
            CMD_LOAD: begin
                if (sym < SYMBOL_COUNT) begin
                    code_tbl[sym] = value;
                    len_tbl[sym]  = (int'(len) > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
                end
            end
            CMD_ENCODE: begin
                if (sym < SYMBOL_COUNT) clen = int'(len_tbl[sym]);
                if (clen == 0) begin
                    owed_words.push_back('{data: '0, kind: KIND_ERR, last: 1'b1});
                end else begin
                    code = code_tbl[sym];
                    // shift code bits in MSB first, emit each full byte
                    for (int i = clen; i > 0; i--) begin
                        acc_byte[7 - acc_fill] = code[i-1];
                        acc_fill++;
                        if (acc_fill == 8) begin
                            owed_words.push_back('{data: acc_byte, kind: KIND_DATA,
                                                   last: 1'b0});
                            n++;
                            acc_byte = '0;
                            acc_fill = 0;
                        end
                    end
                    if (n > 0) owed_words[owed_words.size()-1].last = 1'b1;
                end
            end
            CMD_FLUSH: begin
                if (acc_fill > 0) begin
                    owed_words.push_back('{data: acc_byte, kind: KIND_DATA, last: 1'b0});
                    owed_words.push_back('{data: BYTE_W'(8 - acc_fill), kind: KIND_PAD,
                                           last: 1'b1});
                end else begin
                    owed_words.push_back('{data: '0, kind: KIND_PAD, last: 1'b1});
                end
                acc_byte = '0;
                acc_fill = 0;
            end
            default: ;
        endcase
    endtask

    // Sample both channels at the edge; predict first, then compare
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            for (int k = 0; k < 256; k++) begin
                code_tbl[k] = '0;
                len_tbl[k]  = '0;
            end
            acc_byte = '0;
            acc_fill = 0;
            owed_words.delete();
        end else begin
            if (i_cmd_mon.valid && i_cmd_mon.ready)
                pack_command(i_cmd_mon.cmd, i_cmd_mon.symbol, i_cmd_mon.code_value,
                             i_cmd_mon.code_len);
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (owed_words.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word byte %h kind %0d last %b",
                                            i_res_mon.out_byte, i_res_mon.out_kind,
                                            i_res_mon.last));
                end else begin
                    want = owed_words.pop_front();
                    if (i_res_mon.out_byte !== want.data)
                        flag_mismatch($sformatf("out_byte %h, want %h",
                                                i_res_mon.out_byte, want.data));
                    if (i_res_mon.out_kind !== want.kind)
                        flag_mismatch($sformatf("out_kind %0d, want %0d",
                                                i_res_mon.out_kind, want.kind));
                    if (i_res_mon.last !== want.last)
                        flag_mismatch($sformatf("last %b, want %b",
                                                i_res_mon.last, want.last));
                end
            end
        end
        o_fail_count <= mismatches;
        o_owed_count <= owed_words.size();
    end

    initial begin
        mismatches = 0;
    end

endmodule

`default_nettype wire

/* dv/tb_huffman_code_bit_packer_unit.sv */
`timescale 1ns / 100ps
// tb_huffman_code_bit_packer_unit: drives table loads, encodes and flushes into the
// bit packer with random idling on both channels; the checker predicts and compares.
// Depends on hcbp_pkg, hcbp_ifs, huffman_code_bit_packer_unit and hcbp_packed_word_checker.
`default_nettype none

module tb_huffman_code_bit_packer_unit;
    import hcbp_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    int   fail_cnt;
    int   owed_cnt;
    bit   no_gaps;

    hcbp_cmd_if cmd_if ();
    hcbp_res_if res_if ();

    huffman_code_bit_packer_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (cmd_if),
        .o_res_if (res_if)
    );

    hcbp_packed_word_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_if),
        .i_res_mon    (res_if),
        .o_fail_count (fail_cnt),
        .o_owed_count (owed_cnt)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("** huffman_code_bit_packer_unit: FAILED **");
        $finish;
    end

    // Symbols loaded with a nonzero length; stale entries just give error words
    bit [7:0] mapped_syms [$];

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [5:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 6'($urandom_range(1, 8));
        if (r < 85) return 6'($urandom_range(9, 16));
        if (r < 95) return 6'($urandom_range(17, 32));
        if (r < 98) return 6'($urandom_range(33, 63));
        return 6'd0;
    endfunction

    // Present one command word and hold it until accepted
    task automatic send_word(input logic [1:0] op, input logic [7:0] sym,
                             input logic [31:0] value, input logic [5:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= op;
        cmd_if.symbol     <= sym;
        cmd_if.code_value <= value;
        cmd_if.code_len   <= len;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic load_entry(input logic [7:0] sym, input logic [31:0] value,
                              input logic [5:0] len);
        send_word(CMD_LOAD, sym, value, len);
        if (len != 0) mapped_syms.push_back(sym);
    endtask

    // Encode and flush ignore the other fields, so fill them with noise
    task automatic encode_sym(input logic [7:0] sym);
        send_word(CMD_ENCODE, sym, $urandom(), 6'($urandom_range(0, 63)));
    endtask

    task automatic flush_bits();
        send_word(CMD_FLUSH, 8'($urandom_range(0, 255)), $urandom(),
                  6'($urandom_range(0, 63)));
    endtask

    // Wait for the checker to report nothing owed
    task automatic drain_words();
        @(posedge i_clk);
        while (owed_cnt != 0) @(posedge i_clk);
    endtask

    // Result ready: short high and low runs, now and then a long stall
    initial begin : res_ready_drive
        int hold;
        bit level;
        int r;
        hold  = 0;
        level = 1'b1;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                r = $urandom_range(0, 99);
                if (no_gaps || r < 70) begin
                    level = 1'b1;
                    hold  = $urandom_range(1, 6);
                end else if (r < 95) begin
                    level = 1'b0;
                    hold  = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    hold  = $urandom_range(10, 40);
                end
            end
            hold--;
            res_if.ready <= level;
        end
    end

    // Stimulus
    initial begin : stimulus
        int rand_items;
        int phase;
        int n_loads;
        int n_enc;
        int r;
        rand_items = 0;
        phase      = 0;
        no_gaps    = 1'b0;
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.cmd        <= CMD_LOAD;
        cmd_if.symbol     <= '0;
        cmd_if.code_value <= '0;
        cmd_if.code_len   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty flush, unmapped symbol, longest codes, length saturation,
        // byte-aligned encodes, ignored command, remapping to zero length
        send_word(CMD_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
        send_word(CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
        load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
        encode_sym(8'hFF);
        load_entry(8'h00, 32'h0000_0000, 6'd1);
        load_entry(8'hAA, 32'h0000_0005, 6'd3);
        load_entry(8'h55, 32'hAAAA_AAAA, 6'h3F);
        load_entry(8'h01, 32'h1234_5678, 6'd33);
        encode_sym(8'h00);
        encode_sym(8'hAA);
        flush_bits();
        encode_sym(8'h00);
        encode_sym(8'h55);
        flush_bits();
        encode_sym(8'h01);
        send_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        flush_bits();
        load_entry(8'h80, 32'h0000_007F, 6'd7);
        encode_sym(8'h00);
        encode_sym(8'h80);
        load_entry(8'hFF, 32'h0000_0000, 6'd0);
        encode_sym(8'hAA);
        encode_sym(8'hFF);
        flush_bits();

        // Random: each phase loads a few entries, then encodes a run and flushes
        while (rand_items < 85) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            n_loads = $urandom_range(3, 8);
            repeat (n_loads) begin
                load_entry(8'($urandom_range(0, 255)), $urandom(), pick_len());
                rand_items++;
            end
            n_enc = $urandom_range(6, 18);
            repeat (n_enc) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    encode_sym(mapped_syms[$urandom_range(0, mapped_syms.size() - 1)]);
                    rand_items++;
                end else if (r < 88) begin
                    encode_sym(8'($urandom_range(0, 255)));
                    rand_items++;
                end else if (r < 94) begin
                    flush_bits();
                    rand_items++;
                end else if (r < 97) begin
                    load_entry(8'($urandom_range(0, 255)), $urandom(), pick_len());
                    rand_items++;
                end else begin
                    send_word(CMD_UNUSED, 8'($urandom_range(0, 255)), $urandom(),
                              6'($urandom_range(0, 63)));
                end
            end
            flush_bits();
            rand_items++;
            phase++;
            // hold off the sender until every owed word is out
            if (phase == 2) begin
                cmd_if.valid <= 1'b0;
                drain_words();
            end
        end

        cmd_if.valid <= 1'b0;
        no_gaps = 1'b0;
        drain_words();
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && owed_cnt == 0)
            $display("** huffman_code_bit_packer_unit: PASSED **");
        else
            $display("** huffman_code_bit_packer_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

/* huffman_code_bit_packer_unit.f */
src/hcbp_pkg.sv
src/hcbp_ifs.sv
src/hcbp_emitter.sv
src/huffman_code_bit_packer_unit.sv
dv/hcbp_packed_word_checker.sv
dv/tb_huffman_code_bit_packer_unit.sv
